>>> rtl/bsr_pkg.sv
package bsr_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH    = 3'd0,
        MODE_POP     = 3'd1,
        MODE_PRINT   = 3'd2,
        MODE_ROT_DN  = 3'd3,
        MODE_ROT_UP  = 3'd4,
        MODE_PEEK    = 3'd5,
        MODE_DUP     = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        KIND_FULL        = 3'd0,
        KIND_EMPTY       = 3'd1,
        KIND_PEEK        = 3'd2,
        KIND_PRINT_ENTRY = 3'd3,
        KIND_PRINT_EMPTY = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH,
        OP_POP,
        OP_DUP,
        OP_ROT_DN,
        OP_ROT_UP,
        OP_ROT_ALL
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_PRINT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] push_byte;
        logic [4:0] depth;
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic       scan_last;
        logic [7:0] top_byte;
    } status_t;

    localparam logic [4:0] CAP_RESET = 5'd16;

endpackage

>>> rtl/bsr_dpath.sv
module bsr_dpath
    import bsr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    input  cmd_t       cmd,
    output status_t    stat
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 5) ? FW : 5;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    cells_reg [DEPTH];
    logic [7:0]    cells_next [DEPTH];
    logic [7:0]    prev_val [DEPTH];
    logic [7:0]    next_val [DEPTH];
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] scan_reg, scan_next;
    logic [4:0]    cap_reg, cap_next;
    logic [CW-1:0] fill_ext, cap_eff, span, sel_idx;
    logic          rot_ok;
    logic [7:0]    rot_pick;

    assign fill_ext = CW'(fill_reg);
    assign cap_eff  = (CW'(cap_reg) < CW'(DEPTH)) ? CW'(cap_reg) : CW'(DEPTH);
    assign span     = (cmd.op == OP_ROT_ALL) ? fill_ext : CW'(cmd.depth);
    assign sel_idx  = span - CW'(1);
    assign rot_ok   = (span != '0) && (span <= fill_ext);
    assign rot_pick = cells_reg[sel_idx[IW-1:0]];

    assign stat.full      = (fill_ext >= cap_eff);
    assign stat.empty     = (fill_reg == '0);
    assign stat.scan_last = (scan_reg == fill_reg - FW'(1));
    assign stat.top_byte  = cells_reg[0];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam logic [CW-1:0] POS = CW'(g);
        logic [7:0] nxt;

        if (g > 0)
        begin : g_prev
            assign prev_val[g] = cells_reg[g-1];
        end
        else
        begin : g_prev_top
            assign prev_val[g] = cells_reg[0];
        end

        if (g < DEPTH - 1)
        begin : g_next
            assign next_val[g] = cells_reg[g+1];
        end
        else
        begin : g_next_bottom
            assign next_val[g] = cells_reg[g];
        end

        always_comb
        begin
            nxt = cells_reg[g];
            unique case (cmd.op)
                OP_PUSH:
                begin
                    nxt = (POS == '0) ? cmd.push_byte : prev_val[g];
                end
                OP_DUP:
                begin
                    nxt = prev_val[g];
                end
                OP_POP:
                begin
                    nxt = next_val[g];
                end
                OP_ROT_UP, OP_ROT_ALL:
                begin
                    if (rot_ok)
                    begin
                        if (POS < sel_idx)
                            nxt = next_val[g];
                        else if (POS == sel_idx)
                            nxt = cells_reg[0];
                    end
                end
                OP_ROT_DN:
                begin
                    if (rot_ok)
                    begin
                        if (POS == '0)
                            nxt = rot_pick;
                        else if (POS <= sel_idx)
                            nxt = prev_val[g];
                    end
                end
                default:
                begin
                    nxt = cells_reg[g];
                end
            endcase
        end

        assign cells_next[g] = nxt;
    end

    always_comb
    begin
        fill_next = fill_reg;
        scan_next = scan_reg;
        cap_next  = cfg_we ? cfg_data : cap_reg;
        unique case (cmd.op)
            OP_PUSH, OP_DUP:
            begin
                fill_next = fill_reg + FW'(1);
            end
            OP_POP:
            begin
                fill_next = fill_reg - FW'(1);
            end
            OP_ROT_ALL:
            begin
                // wrap the scan index once the whole stack has gone by
                scan_next = stat.scan_last ? '0 : scan_reg + FW'(1);
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            scan_reg <= '0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            fill_reg <= fill_next;
            scan_reg <= scan_next;
            cap_reg  <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

endmodule

>>> rtl/bsr_ctrl.sv
module bsr_ctrl
    import bsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    output cmd_t        cmd,
    input  status_t     stat
);

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       slot_free, accept, emit;
    kind_t      emit_kind;
    logic [7:0] emit_byte;
    logic       emit_last;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NOP;
        cmd.push_byte = s_tdata[7:0];
        cmd.depth     = s_tdata[12:8];
        emit          = 1'b0;
        emit_kind     = KIND_EMPTY;
        emit_byte     = 8'd0;
        emit_last     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(s_tuser))
                        MODE_PUSH:
                        begin
                            if (stat.full)
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_FULL;
                            end
                            else
                                cmd.op = OP_PUSH;
                        end
                        MODE_POP:
                        begin
                            if (stat.empty)
                                emit = 1'b1;
                            else
                                cmd.op = OP_POP;
                        end
                        MODE_PRINT:
                        begin
                            if (stat.empty)
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_PRINT_EMPTY;
                            end
                            else
                                state_next = ST_PRINT;
                        end
                        MODE_ROT_DN:
                        begin
                            cmd.op = OP_ROT_DN;
                        end
                        MODE_ROT_UP:
                        begin
                            cmd.op = OP_ROT_UP;
                        end
                        MODE_PEEK:
                        begin
                            emit = 1'b1;
                            if (!stat.empty)
                            begin
                                emit_kind = KIND_PEEK;
                                emit_byte = stat.top_byte;
                            end
                        end
                        MODE_DUP:
                        begin
                            if (stat.full)
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_FULL;
                            end
                            else if (stat.empty)
                                emit = 1'b1;
                            else
                                cmd.op = OP_DUP;
                        end
                        default:
                        begin
                            cmd.op = OP_NOP;
                        end
                    endcase
                end
            end
            ST_PRINT:
            begin
                // emit the top, then rotate the whole stack up by one
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_PRINT_ENTRY;
                    emit_byte = stat.top_byte;
                    emit_last = stat.scan_last;
                    cmd.op    = OP_ROT_ALL;
                    if (stat.scan_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/byte_stack_with_rotate.sv
// Channel   Direction  tdata                          tuser      tlast
// s_*       in         push_byte, rotate_depth        mode       -
// m_*       out        data_byte                      kind       last
// cfg_*     in         capacity                       -          -
//
// Push, pop, duplicate, peek and both rotates act on the stack cells directly; the stack is
// a row of shift cells, so all entries move in parallel.
// Print sends one entry through the output register per cycle while the output is not
// stalled, as the stack rotates up by one, ending where it began.
// Reset clears the fill count and loads capacity 16; stack contents are not reset.
// A stalled output holds the controller and blocks the next request.
module byte_stack_with_rotate
    import bsr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] push_byte, [12:8] rotate_depth, [15:13] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data
);

    cmd_t    cmd;
    status_t stat;

    bsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    bsr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> rtl/bsr_checker.sv
module bsr_checker
    import bsr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    logic status_kind;

    assign status_kind = (m_tuser == KIND_FULL) || (m_tuser == KIND_EMPTY)
                      || (m_tuser == KIND_PRINT_EMPTY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while stalled");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status_kind |-> m_tdata == 8'd0)
        else $error("status result carries data");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_PRINT_ENTRY |-> m_tlast)
        else $error("single result without last");

    // a print entry that is not the last one means the print is still running
    a_print_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_PRINT_ENTRY && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a print");

endmodule

bind byte_stack_with_rotate bsr_checker u_bsr_checker (.*);
